/* src/spcp_pkg.sv */
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types and constants of the segment pair closest points block.
// ----------------------------------------------------------------------------
package spcp_pkg;

  localparam int PARAM_W = 17;
  localparam int FRAC_W = 16;
  localparam logic [PARAM_W-1:0] PARAM_ONE = 17'h10000;
  localparam int QSTEPS = 17;
  localparam int DIST_W = 63;
  localparam int OUT_TDATA_W = 104;
  localparam int TUSER_W = 2;
  localparam int TU_PARALLEL = 0;
  localparam int TU_DEGEN = 1;

  // How a quotient is settled: forced to zero, forced to one, or divided.
  typedef enum logic [1:0] {
    QM_ZERO,
    QM_ONE,
    QM_DIV
  } qmode_t;

endpackage

/* src/spcp_mul.sv */
// ----------------------------------------------------------------------------
// spcp_mul
// Two-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module spcp_mul #(
  parameter int AW = 50,
  parameter int BW = 50
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AH+BH-1:0]   hh;
  logic signed [AH+BL:0]     hl;
  logic signed [AL+BH:0]     lh;
  logic        [AL+BL-1:0]   ll;

  logic signed [AH-1:0] ah;
  logic signed [BH-1:0] bh;
  logic        [AL-1:0] al;
  logic        [BL-1:0] bl;

  assign ah = a[AW-1:AL];
  assign al = a[AL-1:0];
  assign bh = b[BW-1:BL];
  assign bl = b[BL-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= ah * bh;
      hl <= ah * $signed({1'b0, bl});
      lh <= $signed({1'b0, al}) * bh;
      ll <= al * bl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= $signed((PW'(hh) << (AL + BL)) + (PW'(hl) << BL) + (PW'(lh) << AL) + PW'(ll));
    end
  end

endmodule

/* src/spcp_quot.sv */
// ----------------------------------------------------------------------------
// spcp_quot
// Pipelined restoring divider giving a clamped, rounded Q1.16 quotient.
// ----------------------------------------------------------------------------
module spcp_quot import spcp_pkg::*; #(
  parameter int XW = 101,
  parameter int SIDE_W = 2
) (
  input  logic                 clk,
  input  logic                 en,
  input  qmode_t               mode,
  input  logic signed [XW-1:0] num,
  input  logic signed [XW-1:0] den,
  input  logic [SIDE_W-1:0]    side_in,
  output logic [PARAM_W-1:0]   q,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int LAT = QSTEPS + 3;

  qmode_t               m1;
  logic signed [XW-1:0] n1;
  logic signed [XW-1:0] d1;

  qmode_t               mode_q [QSTEPS+1];
  logic [XW-1:0]        rem_q  [QSTEPS+1];
  logic [XW-1:0]        den_q  [QSTEPS+1];
  logic [PARAM_W-1:0]   qa_q   [QSTEPS+1];
  logic [SIDE_W-1:0]    side_q [LAT];

  // Make the divisor positive first.
  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= mode;
      if (den[XW-1]) begin
        n1 <= -num;
        d1 <= -den;
      end else begin
        n1 <= num;
        d1 <= den;
      end
    end
  end

  // A zero divisor or a non-positive numerator gives zero; num >= den clamps.
  always_ff @(posedge clk) begin
    if (en) begin
      if (m1 == QM_DIV) begin
        if (d1 == '0 || n1[XW-1] || n1 == '0) begin
          mode_q[0] <= QM_ZERO;
        end else if (n1 >= d1) begin
          mode_q[0] <= QM_ONE;
        end else begin
          mode_q[0] <= QM_DIV;
        end
      end else begin
        mode_q[0] <= m1;
      end
      rem_q[0] <= n1;
      den_q[0] <= d1;
      qa_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QSTEPS; k++) begin : g_step
    logic [XW:0] r2;
    logic        ge;
    logic [XW:0] diff;
    assign r2   = {rem_q[k], 1'b0};
    assign ge   = r2 >= {1'b0, den_q[k]};
    assign diff = r2 - {1'b0, den_q[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        mode_q[k+1] <= mode_q[k];
        den_q[k+1]  <= den_q[k];
        rem_q[k+1]  <= ge ? diff[XW-1:0] : r2[XW-1:0];
        qa_q[k+1]   <= {qa_q[k][PARAM_W-2:0], ge};
      end
    end
  end

  // The quotient holds num * 2^17 / den; halving with a carry rounds half up.
  logic [PARAM_W:0] rnd;
  assign rnd = {1'b0, qa_q[QSTEPS]} + 1'b1;

  always_ff @(posedge clk) begin
    if (en) begin
      case (mode_q[QSTEPS])
        QM_ONE:  q <= PARAM_ONE;
        QM_DIV:  q <= rnd[PARAM_W:1];
        default: q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_out = side_q[LAT-1];

endmodule

/* src/segment_pair_closest_points_top.sv */
// ----------------------------------------------------------------------------
// segment_pair_closest_points_top
// Closest points and squared distance of two 3-D segments, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the two dividers set the depth.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets parallel_limit to 1.
module segment_pair_closest_points_top import spcp_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  localparam int IN_TW = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // offset_x, offset_y, offset_z, dir0_x, dir0_y, dir0_z, dir1_x, dir1_y, dir1_z
  input  logic [IN_TW-1:0]       s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // s_param, t_param, dist_sq
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // parallel_flag, degenerate_flag
  output logic [TUSER_W-1:0]     m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = 2 * W + 2;
  localparam int PW  = 2 * DW;
  localparam int XW  = PW + 1;
  localparam int SW  = DW + 2;
  localparam int VW  = W + 19;
  localparam int ACW = (2 * VW + 2 > 96) ? 2 * VW + 2 : 96;
  localparam int QLAT = QSTEPS + 3;
  localparam int NSTG = 8 + QLAT + 5;

  logic [NSTG-1:0] vld;
  logic            en;
  logic [31:0]     parallel_limit;

  assign en        = !vld[NSTG-1] || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[NSTG-1];
  assign cfg_ready = 1'b1;

  function automatic logic signed [W-1:0] fld(input logic [9*W-1:0] v, input int i);
    fld = v[i*W +: W];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= '0;
      parallel_limit <= 32'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        parallel_limit <= cfg_data;
      end
      if (en) begin
        vld <= {vld[NSTG-2:0], s_tvalid};
      end
    end
  end

  // Stage 0: input register; coordinates ride along to the divider.
  logic [9*W-1:0] crd_q [8];

  always_ff @(posedge clk) begin
    if (en) begin
      crd_q[0] <= s_tdata[9*W-1:0];
      for (int k = 1; k < 8; k++) begin
        crd_q[k] <= crd_q[k-1];
      end
    end
  end

  // Stage 1: the fifteen products of the five dot products.
  logic signed [2*W-1:0] pa [3];
  logic signed [2*W-1:0] pb [3];
  logic signed [2*W-1:0] pc [3];
  logic signed [2*W-1:0] pd [3];
  logic signed [2*W-1:0] pe [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= fld(crd_q[0], 3 + i) * fld(crd_q[0], 3 + i);
        pb[i] <= fld(crd_q[0], 3 + i) * fld(crd_q[0], 6 + i);
        pc[i] <= fld(crd_q[0], 6 + i) * fld(crd_q[0], 6 + i);
        pd[i] <= fld(crd_q[0], 3 + i) * fld(crd_q[0], i);
        pe[i] <= fld(crd_q[0], 6 + i) * fld(crd_q[0], i);
      end
    end
  end

  // Stage 2: coefficients a..e, carried on to stage 6.
  logic signed [DW-1:0] a_q [5];
  logic signed [DW-1:0] b_q [5];
  logic signed [DW-1:0] c_q [5];
  logic signed [DW-1:0] d_q [5];
  logic signed [DW-1:0] e_q [5];

  always_ff @(posedge clk) begin
    if (en) begin
      a_q[0] <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
      b_q[0] <= -(DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]));
      c_q[0] <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
      d_q[0] <= DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]);
      e_q[0] <= -(DW'(pe[0]) + DW'(pe[1]) + DW'(pe[2]));
      for (int k = 1; k < 5; k++) begin
        a_q[k] <= a_q[k-1];
        b_q[k] <= b_q[k-1];
        c_q[k] <= c_q[k-1];
        d_q[k] <= d_q[k-1];
        e_q[k] <= e_q[k-1];
      end
    end
  end

  // Stages 3 and 4: the six wide products.
  logic signed [PW-1:0] ac4, bb4, be4, cd4, bd4, ae4;

  spcp_mul #(.AW(DW), .BW(DW)) u_mul_ac (.clk, .en, .a(a_q[0]), .b(c_q[0]), .p(ac4));
  spcp_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clk, .en, .a(b_q[0]), .b(b_q[0]), .p(bb4));
  spcp_mul #(.AW(DW), .BW(DW)) u_mul_be (.clk, .en, .a(b_q[0]), .b(e_q[0]), .p(be4));
  spcp_mul #(.AW(DW), .BW(DW)) u_mul_cd (.clk, .en, .a(c_q[0]), .b(d_q[0]), .p(cd4));
  spcp_mul #(.AW(DW), .BW(DW)) u_mul_bd (.clk, .en, .a(b_q[0]), .b(d_q[0]), .p(bd4));
  spcp_mul #(.AW(DW), .BW(DW)) u_mul_ae (.clk, .en, .a(a_q[0]), .b(e_q[0]), .p(ae4));

  // Stage 5: determinant and the unclamped numerators.
  logic signed [XW-1:0] det5, sn5, tn5;

  always_ff @(posedge clk) begin
    if (en) begin
      det5 <= XW'(ac4) - XW'(bb4);
      sn5  <= XW'(be4) - XW'(cd4);
      tn5  <= XW'(bd4) - XW'(ae4);
    end
  end

  // Stage 6: wide compares.
  logic signed [XW-1:0] det6, sn6, tn6;
  logic                 par6, slo6, shi6, tlo6, thi6;

  always_ff @(posedge clk) begin
    if (en) begin
      det6 <= det5;
      sn6  <= sn5;
      tn6  <= tn5;
      par6 <= det5 <= $signed({{(XW-32){1'b0}}, parallel_limit});
      slo6 <= !sn5[XW-1];
      shi6 <= sn5 <= det5;
      tlo6 <= !tn5[XW-1];
      thi6 <= tn5 <= det5;
    end
  end

  // Stage 7: pick the region and set up both quotients.
  qmode_t               sm_n, tm_n;
  logic signed [XW-1:0] snum_n, sden_n, tnum_n, tden_n;
  logic signed [XW-1:0] a_x, b_x, c_x, nd_x, ne_x, nbd_x, nbe_x, nad_x;
  logic signed [SW-1:0] apd, apbd, bpce, bpe, bpd, cpe;
  logic                 azero, czero;

  always_comb begin
    a_x   = XW'(a_q[4]);
    b_x   = XW'(b_q[4]);
    c_x   = XW'(c_q[4]);
    nd_x  = -XW'(d_q[4]);
    ne_x  = -XW'(e_q[4]);
    nbd_x = -(XW'(b_q[4]) + XW'(d_q[4]));
    nbe_x = -(XW'(b_q[4]) + XW'(e_q[4]));
    nad_x = -(XW'(a_q[4]) + XW'(d_q[4]));
    apd   = SW'(a_q[4]) + SW'(d_q[4]);
    apbd  = SW'(a_q[4]) + SW'(b_q[4]) + SW'(d_q[4]);
    bpce  = SW'(b_q[4]) + SW'(c_q[4]) + SW'(e_q[4]);
    bpe   = SW'(b_q[4]) + SW'(e_q[4]);
    bpd   = SW'(b_q[4]) + SW'(d_q[4]);
    cpe   = SW'(c_q[4]) + SW'(e_q[4]);
    azero = a_q[4] == '0;
    czero = c_q[4] == '0;

    sm_n   = QM_ZERO;
    snum_n = a_x;
    sden_n = a_x;
    tm_n   = QM_ZERO;
    tnum_n = c_x;
    tden_n = c_x;

    if (azero || czero) begin
      if (!azero) begin
        sm_n = QM_DIV; snum_n = nd_x; sden_n = a_x;
      end
      if (!czero) begin
        tm_n = QM_DIV; tnum_n = ne_x; tden_n = c_x;
      end
    end else if (par6) begin
      if (b_q[4] > 0) begin
        if (!d_q[4][DW-1]) begin
          sm_n = QM_ZERO;
        end else if (!apd[SW-1]) begin
          sm_n = QM_DIV; snum_n = nd_x; sden_n = a_x;
        end else begin
          sm_n = QM_ONE;
          if (apbd <= 0) begin
            tm_n = QM_ONE;
          end else begin
            tm_n = QM_DIV; tnum_n = nad_x; tden_n = b_x;
          end
        end
      end else begin
        if (apd <= 0) begin
          sm_n = QM_ONE;
        end else if (d_q[4] <= 0) begin
          sm_n = QM_DIV; snum_n = nd_x; sden_n = a_x;
        end else if (!bpd[SW-1]) begin
          tm_n = QM_ONE;
        end else begin
          tm_n = QM_DIV; tnum_n = nd_x; tden_n = b_x;
        end
      end
    end else if (slo6 && shi6 && tlo6 && thi6) begin
      sm_n = QM_DIV; snum_n = sn6; sden_n = det6;
      tm_n = QM_DIV; tnum_n = tn6; tden_n = det6;
    end else if (slo6 && shi6 && tlo6) begin
      tm_n = QM_ONE;
      sm_n = QM_DIV; snum_n = nbd_x; sden_n = a_x;
    end else if (slo6 && shi6) begin
      sm_n = QM_DIV; snum_n = nd_x; sden_n = a_x;
    end else if (slo6 && tlo6 && thi6) begin
      sm_n = QM_ONE;
      tm_n = QM_DIV; tnum_n = nbe_x; tden_n = c_x;
    end else if (slo6 && tlo6) begin
      if (apbd > 0) begin
        tm_n = QM_ONE;
        sm_n = QM_DIV; snum_n = nbd_x; sden_n = a_x;
      end else begin
        sm_n = QM_ONE;
        if (bpce > 0) begin
          tm_n = QM_DIV; tnum_n = nbe_x; tden_n = c_x;
        end else begin
          tm_n = QM_ONE;
        end
      end
    end else if (slo6) begin
      if (apd > 0) begin
        sm_n = QM_DIV; snum_n = nd_x; sden_n = a_x;
      end else begin
        sm_n = QM_ONE;
        if (bpe[SW-1]) begin
          tm_n = QM_DIV; tnum_n = nbe_x; tden_n = c_x;
        end
      end
    end else if (tlo6 && thi6) begin
      tm_n = QM_DIV; tnum_n = ne_x; tden_n = c_x;
    end else if (tlo6) begin
      if (bpd[SW-1]) begin
        tm_n = QM_ONE;
        sm_n = QM_DIV; snum_n = nbd_x; sden_n = a_x;
      end else if (cpe > 0) begin
        tm_n = QM_DIV; tnum_n = ne_x; tden_n = c_x;
      end else begin
        tm_n = QM_ONE;
      end
    end else begin
      if (d_q[4][DW-1]) begin
        sm_n = QM_DIV; snum_n = nd_x; sden_n = a_x;
      end else if (e_q[4][DW-1]) begin
        tm_n = QM_DIV; tnum_n = ne_x; tden_n = c_x;
      end
    end
  end

  qmode_t               sm7, tm7;
  logic signed [XW-1:0] snum7, sden7, tnum7, tden7;
  logic [TUSER_W-1:0]   fl7;

  always_ff @(posedge clk) begin
    if (en) begin
      sm7   <= sm_n;
      tm7   <= tm_n;
      snum7 <= snum_n;
      sden7 <= sden_n;
      tnum7 <= tnum_n;
      tden7 <= tden_n;
      fl7[TU_DEGEN]    <= azero || czero;
      fl7[TU_PARALLEL] <= !(azero || czero) && par6;
    end
  end

  // Stages 8 to 27: the two dividers.
  logic [PARAM_W-1:0] s27, t27;
  logic [9*W-1:0]     crd27;
  logic [TUSER_W-1:0] fl27;

  spcp_quot #(.XW(XW), .SIDE_W(9 * W)) u_quot_s (
    .clk, .en, .mode(sm7), .num(snum7), .den(sden7),
    .side_in(crd_q[7]), .q(s27), .side_out(crd27)
  );

  spcp_quot #(.XW(XW), .SIDE_W(TUSER_W)) u_quot_t (
    .clk, .en, .mode(tm7), .num(tnum7), .den(tden7),
    .side_in(fl7), .q(t27), .side_out(fl27)
  );

  // Stage 28: scale the directions by s and t.
  logic signed [W+17:0] sm28 [3];
  logic signed [W+17:0] tm28 [3];
  logic signed [W-1:0]  dd28 [3];
  logic [PARAM_W-1:0]   s_d [4];
  logic [PARAM_W-1:0]   t_d [4];
  logic [TUSER_W-1:0]   fl_d [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sm28[i] <= $signed({1'b0, s27}) * fld(crd27, 3 + i);
        tm28[i] <= $signed({1'b0, t27}) * fld(crd27, 6 + i);
        dd28[i] <= fld(crd27, i);
      end
      s_d[0]  <= s27;
      t_d[0]  <= t27;
      fl_d[0] <= fl27;
      for (int k = 1; k < 4; k++) begin
        s_d[k]  <= s_d[k-1];
        t_d[k]  <= t_d[k-1];
        fl_d[k] <= fl_d[k-1];
      end
    end
  end

  // Stage 29: separation vector with FRAC_W fraction bits.
  logic signed [VW-1:0] v29 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v29[i] <= (VW'(dd28[i]) <<< FRAC_W) + VW'(sm28[i]) - VW'(tm28[i]);
      end
    end
  end

  // Stages 30 and 31: squares.
  logic signed [2*VW-1:0] sq31 [3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    spcp_mul #(.AW(VW), .BW(VW)) u_mul_sq (
      .clk, .en, .a(v29[i]), .b(v29[i]), .p(sq31[i])
    );
  end

  // Stage 32: sum, round off the 2*FRAC_W fraction bits and saturate.
  logic [ACW-1:0]      acc;
  logic                sat;
  logic [DIST_W-1:0]   dist_out;
  logic [PARAM_W-1:0]  s_out, t_out;
  logic [TUSER_W-1:0]  fl_out;

  assign acc = ACW'(sq31[0]) + ACW'(sq31[1]) + ACW'(sq31[2]) + (ACW'(1) << 31);
  assign sat = |acc[ACW-1:95];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_out <= sat ? {DIST_W{1'b1}} : acc[94:32];
      s_out    <= s_d[3];
      t_out    <= t_d[3];
      fl_out   <= fl_d[3];
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - DIST_W - 2 * PARAM_W){1'b0}}, dist_out, t_out, s_out};
  assign m_tuser = fl_out;

endmodule

/* src/spcp_checker.sv */
// ----------------------------------------------------------------------------
// spcp_checker
// Port-level checks on the result stream of the closest points block.
// ----------------------------------------------------------------------------
module spcp_checker import spcp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [TUSER_W-1:0]     m_tuser
);

  a_s_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[PARAM_W-1:0] <= PARAM_ONE)
    else $error("s_param above one");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2*PARAM_W-1:PARAM_W] <= PARAM_ONE)
    else $error("t_param above one");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[TU_PARALLEL] && m_tuser[TU_DEGEN]))
    else $error("parallel and degenerate both set");

  // A zero-length segment always pins its own parameter at zero.
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[TU_DEGEN] |->
      m_tdata[PARAM_W-1:0] == '0 || m_tdata[2*PARAM_W-1:PARAM_W] == '0)
    else $error("degenerate result with both parameters nonzero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind segment_pair_closest_points_top spcp_checker u_spcp_checker (.*);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment pair closest points block. A predictor
// works out s, t, the squared distance and both flags for each accepted pair
// in exact wide integer arithmetic. Directed pairs, random pairs of several
// shapes under several parallel limits, and a long output stall are covered.
// ----------------------------------------------------------------------------
module tb_top;
  import spcp_pkg::*;

  localparam int CW = 24;
  localparam int IN_TW = ((9 * CW + 7) / 8) * 8;
  localparam int PIPE_LAT = 33;
  localparam int IDLE_LIMIT = 3000;

  typedef logic signed [191:0] wint_t;
  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t pair_t [9];

  typedef struct packed {
    logic [PARAM_W-1:0] s_param;
    logic [PARAM_W-1:0] t_param;
    logic [DIST_W-1:0]  dist_sq;
    logic               parallel_flag;
    logic               degenerate_flag;
  } closest_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TW-1:0]       s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [TUSER_W-1:0]     m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [31:0]            cfg_data = '0;

  closest_t expected_q[$];
  logic [31:0] limit_model;
  int errors = 0;
  int pairs_sent = 0;
  int results_seen = 0;
  int parallel_seen = 0;
  int degen_seen = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  int rx_wait = 0;
  int rx_hold = 0;
  int idle_cycles = 0;

  segment_pair_closest_points_top #(.COORD_WIDTH(CW)) i_dut (.*);

  always #5 clk = ~clk;

  // Rounded, clamped Q1.16 quotient num/den.
  function automatic logic [PARAM_W-1:0] ratio_q16(wint_t num, wint_t den);
    wint_t q;
    if (den == 0) return '0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return '0;
    q = (num * 131072 + den) / (den * 2);
    if (q >= 65536) return PARAM_ONE;
    return q[PARAM_W-1:0];
  endfunction

  function automatic closest_t closest_points(pair_t p, logic [31:0] lim);
    closest_t r;
    wint_t dv[3], m0[3], m1[3];
    wint_t a, b, c, d, e, det, sn, tn, nbe, nbd, acc, v;
    wint_t one;
    logic [PARAM_W-1:0] s, t;
    bit s_lo, s_hi, t_lo, t_hi;
    one = 65536;
    s = '0;
    t = '0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = p[i];
      m0[i] = p[3 + i];
      m1[i] = p[6 + i];
    end
    a = m0[0] * m0[0] + m0[1] * m0[1] + m0[2] * m0[2];
    b = -(m0[0] * m1[0] + m0[1] * m1[1] + m0[2] * m1[2]);
    c = m1[0] * m1[0] + m1[1] * m1[1] + m1[2] * m1[2];
    d = m0[0] * dv[0] + m0[1] * dv[1] + m0[2] * dv[2];
    e = -(m1[0] * dv[0] + m1[1] * dv[1] + m1[2] * dv[2]);
    det = a * c - b * b;
    nbe = -(b + e);
    nbd = -(b + d);
    if (a == 0 || c == 0) begin
      r.degenerate_flag = 1'b1;
      if (c != 0) t = ratio_q16(-e, c);
      if (a != 0) s = ratio_q16(-d, a);
    end else if (det <= $signed({160'd0, lim})) begin
      r.parallel_flag = 1'b1;
      if (b > 0) begin
        if (d >= 0) begin
          s = '0;
          t = '0;
        end else if (-d <= a) begin
          s = ratio_q16(-d, a);
        end else begin
          s = PARAM_ONE;
          t = (-(a + d) >= b) ? PARAM_ONE : ratio_q16(-(a + d), b);
        end
      end else begin
        if (-d >= a) s = PARAM_ONE;
        else if (d <= 0) s = ratio_q16(-d, a);
        else t = (d >= -b) ? PARAM_ONE : ratio_q16(-d, b);
      end
    end else begin
      sn = b * e - c * d;
      tn = b * d - a * e;
      s_lo = sn >= 0;
      s_hi = sn <= det;
      t_lo = tn >= 0;
      t_hi = tn <= det;
      if (s_lo && s_hi && t_lo && t_hi) begin
        s = ratio_q16(sn, det);
        t = ratio_q16(tn, det);
      end else if (s_lo && s_hi && t_lo) begin
        t = PARAM_ONE;
        s = ratio_q16(nbd, a);
      end else if (s_lo && s_hi) begin
        s = ratio_q16(-d, a);
      end else if (s_lo && t_lo && t_hi) begin
        s = PARAM_ONE;
        t = ratio_q16(nbe, c);
      end else if (s_lo && t_lo) begin
        if (a + b + d > 0) begin
          t = PARAM_ONE;
          s = ratio_q16(nbd, a);
        end else begin
          s = PARAM_ONE;
          t = (b + c + e > 0) ? ratio_q16(nbe, c) : PARAM_ONE;
        end
      end else if (s_lo) begin
        if (a + d > 0) s = ratio_q16(-d, a);
        else begin
          s = PARAM_ONE;
          t = (b + e < 0) ? ratio_q16(nbe, c) : '0;
        end
      end else if (t_lo && t_hi) begin
        t = ratio_q16(-e, c);
      end else if (t_lo) begin
        if (b + d < 0) begin
          t = PARAM_ONE;
          s = ratio_q16(nbd, a);
        end else begin
          t = (c + e > 0) ? ratio_q16(-e, c) : PARAM_ONE;
        end
      end else begin
        if (d < 0) s = ratio_q16(-d, a);
        else t = (e < 0) ? ratio_q16(-e, c) : '0;
      end
    end
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      v = dv[i] * one + $signed({175'd0, s}) * m0[i] - $signed({175'd0, t}) * m1[i];
      acc = acc + v * v;
    end
    acc = acc + (wint_t'(1) <<< 31);
    r.dist_sq = (acc[191:95] != 0) ? {DIST_W{1'b1}} : acc[94:32];
    r.s_param = s;
    r.t_param = t;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb_top: result %0d %s got %0h expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  // Output side: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    closest_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected", m_tdata[63:0], 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (m_tdata[16:0] != want.s_param)
          report_mismatch("s_param", 64'(m_tdata[16:0]), 64'(want.s_param));
        if (m_tdata[33:17] != want.t_param)
          report_mismatch("t_param", 64'(m_tdata[33:17]), 64'(want.t_param));
        if (m_tdata[96:34] != want.dist_sq)
          report_mismatch("dist_sq", 64'(m_tdata[96:34]), 64'(want.dist_sq));
        if (m_tuser[TU_PARALLEL] != want.parallel_flag)
          report_mismatch("parallel_flag", 64'(m_tuser[TU_PARALLEL]),
                          64'(want.parallel_flag));
        if (m_tuser[TU_DEGEN] != want.degenerate_flag)
          report_mismatch("degenerate_flag", 64'(m_tuser[TU_DEGEN]),
                          64'(want.degenerate_flag));
        parallel_seen += int'(want.parallel_flag);
        degen_seen += int'(want.degenerate_flag);
      end
      results_seen++;
      rx_wait <= rx_stalls ? $urandom_range(0, 12) : 0;
    end
  end

  // Receiver ready: a long hold set by a test, else per-result random stalls.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Called just after a rising edge; returns just after the transfer edge.
  task automatic send_pair(pair_t p);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) s_tdata[CW*i +: CW] <= p[i];
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(closest_points(p, limit_model));
    pairs_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t rand_coord(int span);
    if (span >= CW) return coord_t'($urandom);
    return coord_t'($signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1)));
  endfunction

  function automatic pair_t make_pair(int dx, int dy, int dz, int ax, int ay, int az,
                                      int bx, int by, int bz);
    pair_t p;
    p = '{coord_t'(dx), coord_t'(dy), coord_t'(dz), coord_t'(ax), coord_t'(ay),
          coord_t'(az), coord_t'(bx), coord_t'(by), coord_t'(bz)};
    return p;
  endfunction

  // Random pair of one of several shapes; most stay small enough to avoid
  // saturating the distance, some are near parallel or have a zero direction.
  function automatic pair_t random_pair();
    pair_t p;
    int span;
    int shape;
    int k;
    shape = $urandom_range(0, 9);
    span = (shape == 0) ? CW : $urandom_range(4, 20);
    for (int i = 0; i < 9; i++) p[i] = rand_coord(span);
    case (shape)
      1, 2: begin
        k = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) p[6 + i] = coord_t'(p[3 + i] * k + rand_coord(2));
      end
      3: begin
        for (int i = 0; i < 3; i++) p[6 + i] = -p[3 + i];
      end
      4: begin
        if ($urandom_range(0, 1)) for (int i = 0; i < 3; i++) p[3 + i] = '0;
        else for (int i = 0; i < 3; i++) p[6 + i] = '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_directed;
    int mx, mn, u;
    mx = 8388607;
    mn = -8388608;
    u = 65536;
    send_pair(make_pair(mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_pair(make_pair(mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_pair(make_pair(mx, mn, mx, mn, mx, mn, mx, mn, mx));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(u, u, 0, 0, 0, 0, u, 0, 0));
    send_pair(make_pair(u, u, 0, u, 0, 0, 0, 0, 0));
    send_pair(make_pair(-u, 0, u, 0, 0, 0, 0, 0, -u));
    // Parallel and antiparallel segments, overlapping and apart.
    send_pair(make_pair(0, u, 0, u, 0, 0, u, 0, 0));
    send_pair(make_pair(-2 * u, u, 0, u, 0, 0, -u, 0, 0));
    send_pair(make_pair(2 * u, u, 0, u, 0, 0, u, 0, 0));
    send_pair(make_pair(u / 2, 0, 0, u, 0, 0, -u, 0, 0));
    // Crossing segments: closest points in the interior.
    send_pair(make_pair(-u / 2, u / 2, u, u, 0, 0, 0, u, 0));
    // Each clamping edge and corner of the parameter square.
    send_pair(make_pair(u / 4, -u / 2, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(2 * u, u / 2, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(-u / 2, -2 * u, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(-u / 2, 2 * u, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(2 * u, 2 * u, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(-2 * u, -2 * u, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(2 * u, -2 * u, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(-2 * u, 2 * u, u, u, 0, 0, 0, u, 0));
    send_pair(make_pair(1, -1, 1, 1, 1, 0, 1, 2, 0));
  endtask

  task automatic test_random(int count);
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 20) begin
        tx_gaps = ~tx_gaps;
        rx_stalls = ~rx_stalls;
      end
      send_pair(random_pair());
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall.
  task automatic test_backpressure;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    @(negedge clk);
    rx_hold = 150;
    for (int n = 0; n < 80; n++) send_pair(random_pair());
  endtask

  initial begin
    limit_model = 32'd1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    write_limit(32'd0);
    test_directed();
    test_random(120);
    write_limit(32'hFFFFFFFF);
    test_random(120);
    write_limit($urandom);
    test_random(120);
    write_limit(32'h0000FFFF);
    test_backpressure();
    test_random(120);
    write_limit(32'd1);
    test_random(50);
    drain();
    $display("tb_top: %0d pairs sent, %0d results checked under six parallel limits",
             pairs_sent, results_seen);
    $display("tb_top: %0d parallel and %0d degenerate results", parallel_seen, degen_seen);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* segment_pair_closest_points_top.f */
src/spcp_pkg.sv
src/spcp_mul.sv
src/spcp_quot.sv
src/segment_pair_closest_points_top.sv
src/spcp_checker.sv
sim/tb_top.sv
